// ===== src/sscr_pkg.sv =====
// Shared types and constants for the sweep-scan closest-return sequencer.
package sscr_pkg;

  localparam int CFG_BITS              = 11;
  localparam int REG_INDEX_BITS        = 1;
  localparam int STEP_BITS_DEFAULT     = 11;
  localparam int DISTANCE_BITS_DEFAULT = 16;

  localparam logic [CFG_BITS-1:0] SWEEP_STEPS_RESET   = CFG_BITS'(400);
  localparam logic [CFG_BITS-1:0] WALL_FOLLOW_RESET   = '0;
  localparam longint unsigned     FAR_DISTANCE        = 64'd20000;

  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_SWEEP_STEPS = 1'b0,
    REG_WALL_FOLLOW = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SCAN    = 2'd1,
    OP_REALIGN = 2'd2,
    OP_ORIGIN  = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] sweep_steps;
    logic [CFG_BITS-1:0] wall_follow_position;
  } cfg_regs_t;

endpackage

// ===== src/sscr_if.sv =====
// Command and result channel interfaces of the sequencer.
interface sscr_cmd_if #(
  parameter int DISTANCE_BITS = sscr_pkg::DISTANCE_BITS_DEFAULT
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               opcode;
  logic [DISTANCE_BITS-1:0] distance;

  modport source (output valid, output opcode, output distance, input ready);
  modport sink   (input valid, input opcode, input distance, output ready);
endinterface

interface sscr_result_if #(
  parameter int STEP_BITS     = sscr_pkg::STEP_BITS_DEFAULT,
  parameter int DISTANCE_BITS = sscr_pkg::DISTANCE_BITS_DEFAULT
);
  logic                     valid;
  logic                     ready;
  logic                     step_pulse;
  logic                     step_direction;
  logic [STEP_BITS-1:0]     rewind_steps;
  logic                     sequence_done;
  logic [DISTANCE_BITS-1:0] closest_distance;
  logic [STEP_BITS-1:0]     closest_step;

  modport source (output valid, output step_pulse, output step_direction,
                  output rewind_steps, output sequence_done,
                  output closest_distance, output closest_step, input ready);
  modport sink   (input valid, input step_pulse, input step_direction,
                  input rewind_steps, input sequence_done,
                  input closest_distance, input closest_step, output ready);
endinterface

// ===== src/sscr_config.sv =====
// Configuration register file: sweep length and wall-follow target.
module sscr_config (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_en,
  input  logic [sscr_pkg::REG_INDEX_BITS-1:0] write_index,
  input  logic [sscr_pkg::CFG_BITS-1:0]       write_data,
  output sscr_pkg::cfg_regs_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sweep_steps          <= sscr_pkg::SWEEP_STEPS_RESET;
      cfg.wall_follow_position <= sscr_pkg::WALL_FOLLOW_RESET;
    end else if (write_en) begin
      unique case (sscr_pkg::reg_index_t'(write_index))
        sscr_pkg::REG_SWEEP_STEPS: cfg.sweep_steps          <= write_data;
        sscr_pkg::REG_WALL_FOLLOW: cfg.wall_follow_position <= write_data;
      endcase
    end
  end

endmodule

// ===== src/sscr_core.sv =====
// Sequencer state and single-pass step update for one command transfer.
module sscr_core #(
  parameter int STEP_BITS     = sscr_pkg::STEP_BITS_DEFAULT,
  parameter int DISTANCE_BITS = sscr_pkg::DISTANCE_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sscr_pkg::cfg_regs_t      cfg,
  input  logic                     accept,
  input  logic [1:0]               opcode,
  input  logic [DISTANCE_BITS-1:0] distance,
  output logic                     step_pulse,
  output logic                     step_direction,
  output logic [STEP_BITS-1:0]     rewind_steps,
  output logic                     sequence_done,
  output logic [DISTANCE_BITS-1:0] closest_distance,
  output logic [STEP_BITS-1:0]     closest_step
);

  localparam int CB = sscr_pkg::CFG_BITS;
  localparam longint unsigned DIST_MAX = (64'd1 << DISTANCE_BITS) - 64'd1;
  localparam logic [DISTANCE_BITS-1:0] FAR =
    (DIST_MAX < sscr_pkg::FAR_DISTANCE) ? DISTANCE_BITS'(DIST_MAX)
                                        : DISTANCE_BITS'(sscr_pkg::FAR_DISTANCE);
  localparam logic [CB+STEP_BITS-1:0] SWEEP_RESET_EXT =
    {{STEP_BITS{1'b0}}, sscr_pkg::SWEEP_STEPS_RESET};

  logic [DISTANCE_BITS-1:0] min_distance, min_distance_next;
  logic [STEP_BITS-1:0]     min_step, min_step_next;
  logic [STEP_BITS-1:0]     step_count, step_count_next;
  logic [STEP_BITS-1:0]     steps_to_move, steps_to_move_next;
  logic [STEP_BITS-1:0]     position, position_next;
  logic                     scanning, scanning_next;
  logic                     returning, returning_next;
  logic                     realigning, realigning_next;
  logic [DISTANCE_BITS-1:0] latched_distance, latched_distance_next;
  logic [STEP_BITS-1:0]     latched_step, latched_step_next;

  logic [CB+STEP_BITS-1:0]  sweep_ext, target_ext;
  logic [STEP_BITS-1:0]     sweep_val, target, step_inc, realign_len;
  logic                     realign_dir;
  logic signed [STEP_BITS:0] remaining;
  logic                     return_more;

  assign sweep_ext   = {{STEP_BITS{1'b0}}, cfg.sweep_steps};
  assign target_ext  = {{STEP_BITS{1'b0}}, cfg.wall_follow_position};
  assign sweep_val   = sweep_ext[STEP_BITS-1:0];
  assign target      = target_ext[STEP_BITS-1:0];
  assign step_inc    = step_count + STEP_BITS'(1);
  assign remaining   = $signed({1'b0, steps_to_move}) - $signed({1'b0, min_step});
  assign return_more = $signed({1'b0, step_inc}) < remaining;
  assign realign_dir = target < position;
  assign realign_len = realign_dir ? (position - target) : (target - position);

  always_comb begin
    min_distance_next     = min_distance;
    min_step_next         = min_step;
    step_count_next       = step_count;
    steps_to_move_next    = steps_to_move;
    position_next         = position;
    scanning_next         = scanning;
    returning_next        = returning;
    realigning_next       = realigning;
    latched_distance_next = latched_distance;
    latched_step_next     = latched_step;
    step_pulse            = 1'b0;
    step_direction        = 1'b0;
    rewind_steps          = '0;
    sequence_done         = 1'b0;

    unique case (sscr_pkg::opcode_t'(opcode))
      sscr_pkg::OP_SCAN:    scanning_next   = 1'b1;
      sscr_pkg::OP_REALIGN: realigning_next = 1'b1;
      sscr_pkg::OP_ORIGIN: begin
        rewind_steps          = position;
        min_distance_next     = FAR;
        min_step_next         = '0;
        step_count_next       = '0;
        steps_to_move_next    = sweep_val;
        position_next         = '0;
        scanning_next         = 1'b0;
        returning_next        = 1'b0;
        realigning_next       = 1'b0;
        latched_distance_next = FAR;
        latched_step_next     = '0;
      end
      sscr_pkg::OP_TICK: begin
        if (scanning) begin
          if (step_count < steps_to_move) begin
            step_count_next = step_inc;
            step_pulse      = 1'b1;
            if (distance < min_distance) begin
              min_distance_next = distance;
              min_step_next     = step_inc;
            end
          end else begin
            step_count_next = '0;
            scanning_next   = 1'b0;
            returning_next  = 1'b1;
            position_next   = '0;
          end
        end else if (returning) begin
          if (return_more) begin
            step_count_next = step_inc;
            step_pulse      = 1'b1;
            step_direction  = 1'b1;
          end else begin
            returning_next        = 1'b0;
            position_next         = min_step;
            step_count_next       = '0;
            latched_distance_next = min_distance;
            latched_step_next     = min_step;
            min_distance_next     = FAR;
            min_step_next         = '0;
            sequence_done         = 1'b1;
          end
        end else if (realigning) begin
          steps_to_move_next = realign_len;
          if (step_count < realign_len) begin
            step_count_next = step_inc;
            step_pulse      = 1'b1;
            step_direction  = realign_dir;
          end else begin
            position_next   = target;
            step_count_next = '0;
            realigning_next = 1'b0;
          end
        end
      end
    endcase
  end

  assign closest_distance = latched_distance_next;
  assign closest_step     = latched_step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance     <= FAR;
      min_step         <= '0;
      step_count       <= '0;
      steps_to_move    <= SWEEP_RESET_EXT[STEP_BITS-1:0];
      position         <= '0;
      scanning         <= 1'b0;
      returning        <= 1'b0;
      realigning       <= 1'b0;
      latched_distance <= FAR;
      latched_step     <= '0;
    end else if (accept) begin
      min_distance     <= min_distance_next;
      min_step         <= min_step_next;
      step_count       <= step_count_next;
      steps_to_move    <= steps_to_move_next;
      position         <= position_next;
      scanning         <= scanning_next;
      returning        <= returning_next;
      realigning       <= realigning_next;
      latched_distance <= latched_distance_next;
      latched_step     <= latched_step_next;
    end
  end

endmodule

// ===== src/sscr_out_queue.sv =====
// Two-entry result queue that parts the command side from the result side.
module sscr_out_queue #(
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  output logic             head_valid,
  input  logic             head_ready,
  output logic [WIDTH-1:0] head_data
);

  logic [1:0]       count;
  logic [WIDTH-1:0] entry0, entry1;
  logic             pop;

  assign pop        = head_valid && head_ready;
  assign head_valid = count != 2'd0;
  assign not_full   = count != 2'd2;
  assign head_data  = entry0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop && count == 2'd2) begin
      entry0 <= entry1;
    end else if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      entry0 <= push_data;
    end
    if (push && ((count == 2'd1 && !pop) || (count == 2'd2 && pop))) begin
      entry1 <= push_data;
    end
  end

endmodule

// ===== src/sweep_scan_closest_return.sv =====
// A result enters the result queue when its command is accepted.
// One command per cycle while the queue has room; single-pass update.
// A two-entry result queue keeps commands flowing while one result waits.
// Reset (rst, synchronous): registers to defaults, sequencer to origin,
// result queue emptied.
module sweep_scan_closest_return #(
  parameter int STEP_BITS     = sscr_pkg::STEP_BITS_DEFAULT,
  parameter int DISTANCE_BITS = sscr_pkg::DISTANCE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                write_en,
  input  logic [sscr_pkg::REG_INDEX_BITS-1:0] write_index,
  input  logic [sscr_pkg::CFG_BITS-1:0]       write_data,
  sscr_cmd_if.sink                            request,
  sscr_result_if.source                       response
);

  localparam int RES_W = 3 + 2 * STEP_BITS + DISTANCE_BITS;

  sscr_pkg::cfg_regs_t      cfg;
  logic                     accept;
  logic                     pulse, direction, done;
  logic [STEP_BITS-1:0]     rewind, cstep;
  logic [DISTANCE_BITS-1:0] cdist;
  logic [RES_W-1:0]         res_in, res_out;
  logic                     not_full;

  assign request.ready = not_full;
  assign accept        = request.valid && not_full;

  sscr_config u_config (
    .clk         (clk),
    .rst         (rst),
    .write_en    (write_en),
    .write_index (write_index),
    .write_data  (write_data),
    .cfg         (cfg)
  );

  sscr_core #(
    .STEP_BITS     (STEP_BITS),
    .DISTANCE_BITS (DISTANCE_BITS)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .accept           (accept),
    .opcode           (request.opcode),
    .distance         (request.distance),
    .step_pulse       (pulse),
    .step_direction   (direction),
    .rewind_steps     (rewind),
    .sequence_done    (done),
    .closest_distance (cdist),
    .closest_step     (cstep)
  );

  assign res_in = {pulse, direction, rewind, done, cdist, cstep};

  sscr_out_queue #(
    .WIDTH (RES_W)
  ) u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (res_in),
    .not_full   (not_full),
    .head_valid (response.valid),
    .head_ready (response.ready),
    .head_data  (res_out)
  );

  assign {response.step_pulse, response.step_direction, response.rewind_steps,
          response.sequence_done, response.closest_distance,
          response.closest_step} = res_out;

endmodule
